[design/cskc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cskc_pkg: shared types, codes and helpers for the cell kind classifier
// Holds the kind codes, the recognizer state codes, the step struct and the
// calendar helpers used by the scanner and the top level.
// ----------------------------------------------------------------------------
package cskc_pkg;

   // result kinds
   localparam logic [2:0] KIND_NONE    = 3'd0;
   localparam logic [2:0] KIND_BOOL    = 3'd1;
   localparam logic [2:0] KIND_INT     = 3'd2;
   localparam logic [2:0] KIND_DEC     = 3'd3;
   localparam logic [2:0] KIND_DATE    = 3'd4;
   localparam logic [2:0] KIND_NAIVE   = 3'd5;
   localparam logic [2:0] KIND_ZONED   = 3'd6;

   localparam logic [3:0] ST_DEAD      = 4'd15;

   // boolean recognizer
   localparam logic [3:0] BL_LEAD      = 4'd0;
   localparam logic [3:0] BL_T         = 4'd1;
   localparam logic [3:0] BL_TR        = 4'd2;
   localparam logic [3:0] BL_TRU       = 4'd3;
   localparam logic [3:0] BL_TRUE      = 4'd4;
   localparam logic [3:0] BL_F         = 4'd5;
   localparam logic [3:0] BL_FA        = 4'd6;
   localparam logic [3:0] BL_FAL       = 4'd7;
   localparam logic [3:0] BL_FALS      = 4'd8;
   localparam logic [3:0] BL_FALSE     = 4'd9;
   localparam logic [3:0] BL_TRAIL     = 4'd10;

   // number recognizer
   localparam logic [3:0] NM_LEAD      = 4'd0;
   localparam logic [3:0] NM_SIGN      = 4'd1;
   localparam logic [3:0] NM_INT       = 4'd2;
   localparam logic [3:0] NM_DOT       = 4'd3;
   localparam logic [3:0] NM_FRAC      = 4'd4;
   localparam logic [3:0] NM_EXP       = 4'd5;
   localparam logic [3:0] NM_EXP_SIGN  = 4'd6;
   localparam logic [3:0] NM_EXP_DIG   = 4'd7;
   localparam logic [3:0] NM_TRAIL     = 4'd8;

   // date / datetime recognizer
   localparam logic [3:0] SP_PREFIX    = 4'd0;
   localparam logic [3:0] SP_SECONDS   = 4'd1;
   localparam logic [3:0] SP_POINT     = 4'd2;
   localparam logic [3:0] SP_FRAC      = 4'd3;
   localparam logic [3:0] SP_ZONE      = 4'd4;
   localparam logic [3:0] SP_OFS_H1    = 4'd5;
   localparam logic [3:0] SP_OFS_H2    = 4'd6;
   localparam logic [3:0] SP_OFS_COLON = 4'd7;
   localparam logic [3:0] SP_OFS_M1    = 4'd8;
   localparam logic [3:0] SP_OFS_M2    = 4'd9;

   localparam logic [4:0] POS_MAX      = 5'd31;

   typedef struct packed {
      logic       fire;
      logic [7:0] char_code;
      logic       last_char;
      logic       no_char;
   } step_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
   endfunction

   function automatic logic is_dig(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   // year is kept as century (first two digits) and low part (last two)
   function automatic logic date_ok(input logic [6:0] cent, input logic [6:0] lo,
                                    input logic [6:0] month, input logic [6:0] day);
      logic       leap;
      logic [4:0] dim;
      leap = ((lo[1:0] == 2'd0) && (lo != 7'd0)) || ((lo == 7'd0) && (cent[1:0] == 2'd0));
      unique case (month)
         7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: dim = 5'd31;
         7'd4, 7'd6, 7'd9, 7'd11:                     dim = 5'd30;
         7'd2:                                        dim = leap ? 5'd29 : 5'd28;
         default:                                     dim = 5'd0;
      endcase
      return (dim != 5'd0) && (day >= 7'd1) && (day <= {2'b00, dim});
   endfunction

endpackage
`default_nettype wire

[design/cskc_scan.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cskc_scan: per-byte recognizers and verdict
// Boolean, number and date/datetime recognizers advance together on each
// byte; the verdict is formed from the updated state on the closing item.
// ----------------------------------------------------------------------------
module cskc_scan (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cskc_pkg::step_type step,
   output logic [2:0]             kind
);

   logic [3:0] bool_ff, bool_in;
   logic [3:0] num_ff, num_in;
   logic       frac_ff, frac_in;
   logic [4:0] pos_ff, pos_in;
   logic [6:0] cent_ff, cent_in;
   logic [6:0] ylo_ff, ylo_in;
   logic [6:0] month_ff, month_in;
   logic [6:0] day_ff, day_in;
   logic       tok_ff, tok_in;
   logic [3:0] stamp_ff, stamp_in;
   logic       zone_ff, zone_in;
   logic       nasc_ff, nasc_in;

   logic [7:0] c;
   logic [7:0] lc;
   logic       ws, dg, ee, sg;
   logic [3:0] dv;

   assign c  = step.char_code;
   assign lc = ((c >= 8'h41) && (c <= 8'h5A)) ? (c + 8'h20) : c;
   assign ws = cskc_pkg::is_space(c);
   assign dg = cskc_pkg::is_dig(c);
   assign ee = (c == 8'h65) || (c == 8'h45);
   assign sg = (c == 8'h2B) || (c == 8'h2D);
   assign dv = c[3:0];

   // byte update (no_char leaves everything as is)
   always_comb begin
      bool_in  = bool_ff;
      num_in   = num_ff;
      frac_in  = frac_ff;
      pos_in   = pos_ff;
      cent_in  = cent_ff;
      ylo_in   = ylo_ff;
      month_in = month_ff;
      day_in   = day_ff;
      tok_in   = tok_ff;
      stamp_in = stamp_ff;
      zone_in  = zone_ff;
      nasc_in  = nasc_ff;
      if (!step.no_char) begin
         if (c[7]) nasc_in = 1'b1;
         if (pos_ff != cskc_pkg::POS_MAX) pos_in = pos_ff + 5'd1;

         // boolean
         unique case (bool_ff)
            cskc_pkg::BL_LEAD:
               if (ws) bool_in = cskc_pkg::BL_LEAD;
               else if (lc == 8'h74) bool_in = cskc_pkg::BL_T;
               else if (lc == 8'h66) bool_in = cskc_pkg::BL_F;
               else bool_in = cskc_pkg::ST_DEAD;
            cskc_pkg::BL_T:    bool_in = (lc == 8'h72) ? cskc_pkg::BL_TR   : cskc_pkg::ST_DEAD;
            cskc_pkg::BL_TR:   bool_in = (lc == 8'h75) ? cskc_pkg::BL_TRU  : cskc_pkg::ST_DEAD;
            cskc_pkg::BL_TRU:  bool_in = (lc == 8'h65) ? cskc_pkg::BL_TRUE : cskc_pkg::ST_DEAD;
            cskc_pkg::BL_F:    bool_in = (lc == 8'h61) ? cskc_pkg::BL_FA   : cskc_pkg::ST_DEAD;
            cskc_pkg::BL_FA:   bool_in = (lc == 8'h6C) ? cskc_pkg::BL_FAL  : cskc_pkg::ST_DEAD;
            cskc_pkg::BL_FAL:  bool_in = (lc == 8'h73) ? cskc_pkg::BL_FALS : cskc_pkg::ST_DEAD;
            cskc_pkg::BL_FALS: bool_in = (lc == 8'h65) ? cskc_pkg::BL_FALSE : cskc_pkg::ST_DEAD;
            cskc_pkg::BL_TRUE, cskc_pkg::BL_FALSE, cskc_pkg::BL_TRAIL:
               bool_in = ws ? cskc_pkg::BL_TRAIL : cskc_pkg::ST_DEAD;
            default: bool_in = cskc_pkg::ST_DEAD;
         endcase

         // number
         unique case (num_ff)
            cskc_pkg::NM_LEAD:
               if (ws) num_in = cskc_pkg::NM_LEAD;
               else if (sg) num_in = cskc_pkg::NM_SIGN;
               else if (dg) num_in = cskc_pkg::NM_INT;
               else if (c == 8'h2E) begin
                  num_in = cskc_pkg::NM_DOT;
                  frac_in = 1'b1;
               end else num_in = cskc_pkg::ST_DEAD;
            cskc_pkg::NM_SIGN:
               if (dg) num_in = cskc_pkg::NM_INT;
               else if (c == 8'h2E) begin
                  num_in = cskc_pkg::NM_DOT;
                  frac_in = 1'b1;
               end else num_in = cskc_pkg::ST_DEAD;
            cskc_pkg::NM_INT:
               if (dg) num_in = cskc_pkg::NM_INT;
               else if (c == 8'h2E) begin
                  num_in = cskc_pkg::NM_FRAC;
                  frac_in = 1'b1;
               end else if (ee) begin
                  num_in = cskc_pkg::NM_EXP;
                  frac_in = 1'b1;
               end else if (ws) num_in = cskc_pkg::NM_TRAIL;
               else num_in = cskc_pkg::ST_DEAD;
            cskc_pkg::NM_DOT: num_in = dg ? cskc_pkg::NM_FRAC : cskc_pkg::ST_DEAD;
            cskc_pkg::NM_FRAC:
               if (dg) num_in = cskc_pkg::NM_FRAC;
               else if (ee) begin
                  num_in = cskc_pkg::NM_EXP;
                  frac_in = 1'b1;
               end else if (ws) num_in = cskc_pkg::NM_TRAIL;
               else num_in = cskc_pkg::ST_DEAD;
            cskc_pkg::NM_EXP:
               if (sg) num_in = cskc_pkg::NM_EXP_SIGN;
               else num_in = dg ? cskc_pkg::NM_EXP_DIG : cskc_pkg::ST_DEAD;
            cskc_pkg::NM_EXP_SIGN: num_in = dg ? cskc_pkg::NM_EXP_DIG : cskc_pkg::ST_DEAD;
            cskc_pkg::NM_EXP_DIG:
               if (dg) num_in = cskc_pkg::NM_EXP_DIG;
               else num_in = ws ? cskc_pkg::NM_TRAIL : cskc_pkg::ST_DEAD;
            cskc_pkg::NM_TRAIL: num_in = ws ? cskc_pkg::NM_TRAIL : cskc_pkg::ST_DEAD;
            default: num_in = cskc_pkg::ST_DEAD;
         endcase

         // date / datetime; hour reuses the month register after the 'T'
         unique case (stamp_ff)
            cskc_pkg::SP_PREFIX:
               priority if ((pos_ff == 5'd4) || (pos_ff == 5'd7)) begin
                  if (c != 8'h2D) stamp_in = cskc_pkg::ST_DEAD;
               end else if ((pos_ff == 5'd13) || (pos_ff == 5'd16)) begin
                  if (c != 8'h3A) stamp_in = cskc_pkg::ST_DEAD;
               end else if (pos_ff == 5'd10) begin
                  if ((c != 8'h54) || !cskc_pkg::date_ok(cent_ff, ylo_ff, month_ff, day_ff))
                     stamp_in = cskc_pkg::ST_DEAD;
                  month_in = 7'd0;
               end else if (!dg) begin
                  stamp_in = cskc_pkg::ST_DEAD;
               end else if (pos_ff <= 5'd1) begin
                  cent_in = (cent_ff << 3) + (cent_ff << 1) + {3'b000, dv};
               end else if (pos_ff <= 5'd3) begin
                  ylo_in = (ylo_ff << 3) + (ylo_ff << 1) + {3'b000, dv};
               end else if (pos_ff <= 5'd6) begin
                  month_in = (month_ff << 3) + (month_ff << 1) + {3'b000, dv};
               end else if (pos_ff <= 5'd9) begin
                  day_in = (day_ff << 3) + (day_ff << 1) + {3'b000, dv};
               end else if (pos_ff <= 5'd12) begin
                  month_in = (month_ff << 3) + (month_ff << 1) + {3'b000, dv};
                  if ((pos_ff == 5'd12) && (month_in > 7'd23)) tok_in = 1'b0;
               end else if ((pos_ff == 5'd14) || (pos_ff == 5'd17)) begin
                  if (dv >= 4'd6) tok_in = 1'b0;
               end else if (pos_ff == 5'd18) begin
                  stamp_in = cskc_pkg::SP_SECONDS;
               end else begin
                  // minute ones digit: only has to be a digit
                  stamp_in = cskc_pkg::SP_PREFIX;
               end
            cskc_pkg::SP_SECONDS:
               if (c == 8'h2E) stamp_in = cskc_pkg::SP_POINT;
               else if (c == 8'h5A) begin
                  stamp_in = cskc_pkg::SP_ZONE;
                  zone_in = 1'b1;
               end else if (sg) stamp_in = cskc_pkg::SP_OFS_H1;
               else stamp_in = cskc_pkg::ST_DEAD;
            cskc_pkg::SP_POINT: stamp_in = dg ? cskc_pkg::SP_FRAC : cskc_pkg::ST_DEAD;
            cskc_pkg::SP_FRAC:
               if (dg) stamp_in = cskc_pkg::SP_FRAC;
               else if (c == 8'h5A) begin
                  stamp_in = cskc_pkg::SP_ZONE;
                  zone_in = 1'b1;
               end else if (sg) stamp_in = cskc_pkg::SP_OFS_H1;
               else stamp_in = cskc_pkg::ST_DEAD;
            cskc_pkg::SP_OFS_H1: stamp_in = dg ? cskc_pkg::SP_OFS_H2 : cskc_pkg::ST_DEAD;
            cskc_pkg::SP_OFS_H2: stamp_in = dg ? cskc_pkg::SP_OFS_COLON : cskc_pkg::ST_DEAD;
            cskc_pkg::SP_OFS_COLON:
               stamp_in = (c == 8'h3A) ? cskc_pkg::SP_OFS_M1 : cskc_pkg::ST_DEAD;
            cskc_pkg::SP_OFS_M1: stamp_in = dg ? cskc_pkg::SP_OFS_M2 : cskc_pkg::ST_DEAD;
            cskc_pkg::SP_OFS_M2:
               if (dg) begin
                  stamp_in = cskc_pkg::SP_ZONE;
                  zone_in = 1'b1;
               end else stamp_in = cskc_pkg::ST_DEAD;
            default: stamp_in = cskc_pkg::ST_DEAD;
         endcase
      end
   end

   // verdict on the updated state, fixed priority
   always_comb begin
      priority if (nasc_in) kind = cskc_pkg::KIND_NONE;
      else if ((bool_in == cskc_pkg::BL_TRUE) || (bool_in == cskc_pkg::BL_FALSE) ||
               (bool_in == cskc_pkg::BL_TRAIL))
         kind = cskc_pkg::KIND_BOOL;
      else if ((num_in == cskc_pkg::NM_INT) || (num_in == cskc_pkg::NM_FRAC) ||
               (num_in == cskc_pkg::NM_EXP_DIG) || (num_in == cskc_pkg::NM_TRAIL))
         kind = frac_in ? cskc_pkg::KIND_DEC : cskc_pkg::KIND_INT;
      else if ((stamp_in == cskc_pkg::SP_PREFIX) && (pos_in == 5'd10) &&
               cskc_pkg::date_ok(cent_in, ylo_in, month_in, day_in))
         kind = cskc_pkg::KIND_DATE;
      else if (tok_in && ((stamp_in == cskc_pkg::SP_SECONDS) ||
                          (stamp_in == cskc_pkg::SP_FRAC)))
         kind = cskc_pkg::KIND_NAIVE;
      else if (tok_in && (stamp_in == cskc_pkg::SP_ZONE) && zone_in)
         kind = cskc_pkg::KIND_ZONED;
      else kind = cskc_pkg::KIND_NONE;
   end

   // closing item returns everything to the start of a cell
   always_ff @(posedge clock) begin
      if (reset || (step.fire && step.last_char)) begin
         bool_ff  <= cskc_pkg::BL_LEAD;
         num_ff   <= cskc_pkg::NM_LEAD;
         frac_ff  <= 1'b0;
         pos_ff   <= 5'd0;
         cent_ff  <= 7'd0;
         ylo_ff   <= 7'd0;
         month_ff <= 7'd0;
         day_ff   <= 7'd0;
         tok_ff   <= 1'b1;
         stamp_ff <= cskc_pkg::SP_PREFIX;
         zone_ff  <= 1'b0;
         nasc_ff  <= 1'b0;
      end else if (step.fire) begin
         bool_ff  <= bool_in;
         num_ff   <= num_in;
         frac_ff  <= frac_in;
         pos_ff   <= pos_in;
         cent_ff  <= cent_in;
         ylo_ff   <= ylo_in;
         month_ff <= month_in;
         day_ff   <= day_in;
         tok_ff   <= tok_in;
         stamp_ff <= stamp_in;
         zone_ff  <= zone_in;
         nasc_ff  <= nasc_in;
      end
   end

endmodule
`default_nettype wire

[design/cell_scalar_kind_classifier.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cell_scalar_kind_classifier: kind of a text cell, one byte per transfer
// Input register, recognizer update and verdict, result register.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ channel: one byte per transfer (req_char_code). req_no_char marks a
//    transfer with no byte; req_last_char marks the transfer that closes the
//    cell. A closing transfer with no bytes before it is an empty cell.
//  - rsp_ channel: one transfer per cell, rsp_kind = none, boolean, integer,
//    decimal, date, naive datetime or zoned datetime.
//  - Path: the result of a closing byte reaches rsp_ through the input
//    register, then the result register.
//  - Throughput: one byte per cycle; a closing byte waits on a receiver stall.
//    The recognizers make one combinational pass per byte between the registers.
//  - Receiver stall: the result register holds; further bytes of the next
//    cell keep flowing, and only a second closing byte waits in the input
//    register until the result register is free.
//  - Reset: synchronous; drops both registers and returns the recognizers to
//    the start of a cell.
// ----------------------------------------------------------------------------
module cell_scalar_kind_classifier (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_char_code,
   input  wire logic       req_last_char,
   input  wire logic       req_no_char,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [2:0]      rsp_kind
);

   // input register
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_char_ff;
   logic       s1_last_ff;
   logic       s1_none_ff;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [2:0] rsp_kind_ff;

   logic               out_free;
   logic               s1_go;
   logic               req_take;
   logic [2:0]         scan_kind;
   cskc_pkg::step_type step;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   // only a closing byte needs room in the result register
   assign s1_go     = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_stall = s1_valid_ff && !s1_go;
   assign req_take  = req_valid && !req_stall;

   assign s1_valid_in  = req_stall ? s1_valid_ff : req_valid;
   assign rsp_valid_in = (s1_go && s1_last_ff) ? 1'b1 : (rsp_valid_ff && rsp_stall);

   assign step.fire      = s1_go;
   assign step.char_code = s1_char_ff;
   assign step.last_char = s1_last_ff;
   assign step.no_char   = s1_none_ff;

   cskc_scan u_scan (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .kind  (scan_kind)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_char_ff <= req_char_code;
         s1_last_ff <= req_last_char;
         s1_none_ff <= req_no_char;
      end
      if (s1_go && s1_last_ff) rsp_kind_ff <= scan_kind;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind  = rsp_kind_ff;

`ifndef ASSERT_OFF
   // back-pressure only from a closing byte facing a blocked result register
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && s1_last_ff && rsp_valid_ff && rsp_stall))
      else $error("input stalled without a blocked result");

   // a closing byte always produces a result in range
   a_close_result: assert property (@(posedge clock) disable iff (reset)
      (s1_go && s1_last_ff) |=> (rsp_valid_ff && (rsp_kind_ff <= cskc_pkg::KIND_ZONED)))
      else $error("closing byte produced no valid result");

   // a held byte keeps its contents
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_go) |=> (s1_valid_ff && $stable(s1_char_ff) && $stable(s1_last_ff)))
      else $error("held input byte changed");

   // a result appears only after a closing byte went through
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_go && s1_last_ff))
      else $error("result without a closing byte");
`endif

endmodule
`default_nettype wire

[tb/tb_cell_scalar_kind_classifier.sv]
// ----------------------------------------------------------------------------
// tb_cell_scalar_kind_classifier: self-checking bench for the cell classifier
// Streams cell text one byte per req_ transfer under several idle patterns,
// predicts the kind of every closed cell and checks each rsp_ transfer in
// order against that prediction.
// ----------------------------------------------------------------------------
module tb_cell_scalar_kind_classifier;
   import cskc_pkg::*;

   // -------------------------------------------------------------------------
   // Kind predictor plus the in-order store of predicted kinds.
   // Three recognizers (boolean, number, date/time stamp) advance on every
   // byte; the verdict is taken when a cell closes, then all state clears.
   // -------------------------------------------------------------------------
   class kind_scoreboard;
      logic [3:0]  bool_st;
      logic [3:0]  num_st;
      logic [3:0]  stamp_st;
      logic        num_frac_exp;
      logic        zone_seen;
      logic        high_byte;
      logic        hms_ok;
      logic [4:0]  pos;
      logic [13:0] year;
      logic [6:0]  mon;       // holds the hour once the 'T' byte is past
      logic [6:0]  day;
      logic [2:0]  kind_q[$];
      int unsigned errors;
      int unsigned bytes_noted;
      int unsigned kind_count[7];

      function new();
         clear_cell();
         errors      = 0;
         bytes_noted = 0;
         foreach (kind_count[k]) kind_count[k] = 0;
      endfunction

      function void clear_cell();
         bool_st      = BL_LEAD;
         num_st       = NM_LEAD;
         stamp_st     = SP_PREFIX;
         num_frac_exp = 1'b0;
         zone_seen    = 1'b0;
         high_byte    = 1'b0;
         hms_ok       = 1'b1;
         pos          = '0;
         year         = '0;
         mon          = '0;
         day          = '0;
      endfunction

      function logic is_ws(logic [7:0] c);
         return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
      endfunction

      function logic is_num_char(logic [7:0] c);
         return c >= "0" && c <= "9";
      endfunction

      // Gregorian month length, zero for a month out of range
      function int unsigned days_in(int unsigned y, int unsigned m);
         bit leap;
         leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
         case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return leap ? 29 : 28;
            default:               return 0;
         endcase
      endfunction

      function logic date_valid();
         int unsigned dim;
         dim = days_in(32'(year), 32'(mon));
         return dim != 0 && day >= 1 && 32'(day) <= dim;
      endfunction

      function void step_bool(logic [7:0] c);
         logic [7:0] lc;
         lc = (c >= "A" && c <= "Z") ? c + 8'h20 : c;
         case (bool_st)
            BL_LEAD:
               if (is_ws(c))      bool_st = BL_LEAD;
               else if (lc == "t") bool_st = BL_T;
               else if (lc == "f") bool_st = BL_F;
               else               bool_st = ST_DEAD;
            BL_T:    bool_st = (lc == "r") ? BL_TR    : ST_DEAD;
            BL_TR:   bool_st = (lc == "u") ? BL_TRU   : ST_DEAD;
            BL_TRU:  bool_st = (lc == "e") ? BL_TRUE  : ST_DEAD;
            BL_F:    bool_st = (lc == "a") ? BL_FA    : ST_DEAD;
            BL_FA:   bool_st = (lc == "l") ? BL_FAL   : ST_DEAD;
            BL_FAL:  bool_st = (lc == "s") ? BL_FALS  : ST_DEAD;
            BL_FALS: bool_st = (lc == "e") ? BL_FALSE : ST_DEAD;
            BL_TRUE, BL_FALSE, BL_TRAIL:
               bool_st = is_ws(c) ? BL_TRAIL : ST_DEAD;
            default: bool_st = ST_DEAD;
         endcase
      endfunction

      function void step_num(logic [7:0] c);
         logic d, ws, ex, sg;
         d  = is_num_char(c);
         ws = is_ws(c);
         ex = (c == "e") || (c == "E");
         sg = (c == "+") || (c == "-");
         case (num_st)
            NM_LEAD:
               if (ws)     num_st = NM_LEAD;
               else if (sg) num_st = NM_SIGN;
               else if (d)  num_st = NM_INT;
               else if (c == ".") begin
                  num_frac_exp = 1'b1;
                  num_st = NM_DOT;
               end else    num_st = ST_DEAD;
            NM_SIGN:
               if (d) num_st = NM_INT;
               else if (c == ".") begin
                  num_frac_exp = 1'b1;
                  num_st = NM_DOT;
               end else num_st = ST_DEAD;
            NM_INT:
               if (d) num_st = NM_INT;
               else if (c == ".") begin
                  num_frac_exp = 1'b1;
                  num_st = NM_FRAC;
               end else if (ex) begin
                  num_frac_exp = 1'b1;
                  num_st = NM_EXP;
               end else if (ws) num_st = NM_TRAIL;
               else num_st = ST_DEAD;
            NM_DOT:      num_st = d ? NM_FRAC : ST_DEAD;
            NM_FRAC:
               if (d) num_st = NM_FRAC;
               else if (ex) begin
                  num_frac_exp = 1'b1;
                  num_st = NM_EXP;
               end else if (ws) num_st = NM_TRAIL;
               else num_st = ST_DEAD;
            NM_EXP:
               if (sg)     num_st = NM_EXP_SIGN;
               else if (d)  num_st = NM_EXP_DIG;
               else        num_st = ST_DEAD;
            NM_EXP_SIGN: num_st = d ? NM_EXP_DIG : ST_DEAD;
            NM_EXP_DIG:
               if (d)      num_st = NM_EXP_DIG;
               else if (ws) num_st = NM_TRAIL;
               else        num_st = ST_DEAD;
            NM_TRAIL:    num_st = ws ? NM_TRAIL : ST_DEAD;
            default:     num_st = ST_DEAD;
         endcase
      endfunction

      // pos is the index of this byte within the cell
      function void step_stamp(logic [7:0] c);
         logic       d;
         logic [7:0] v;
         d = is_num_char(c);
         v = c - 8'h30;
         case (stamp_st)
            SP_PREFIX:
               if (pos == 4 || pos == 7) begin
                  if (c != "-") stamp_st = ST_DEAD;
               end else if (pos == 13 || pos == 16) begin
                  if (c != ":") stamp_st = ST_DEAD;
               end else if (pos == 10) begin
                  // date is settled here; the month field is reused for the hour
                  if (c != "T" || !date_valid()) stamp_st = ST_DEAD;
                  mon = '0;
               end else if (!d) begin
                  stamp_st = ST_DEAD;
               end else if (pos <= 3) begin
                  year = year * 14'd10 + {6'd0, v};
               end else if (pos <= 6) begin
                  mon = mon * 7'd10 + v[6:0];
               end else if (pos <= 9) begin
                  day = day * 7'd10 + v[6:0];
               end else if (pos <= 12) begin
                  mon = mon * 7'd10 + v[6:0];
                  if (pos == 12 && mon > 23) hms_ok = 1'b0;
               end else if (pos == 14 || pos == 17) begin
                  // tens digit of minute or second
                  if (v > 5) hms_ok = 1'b0;
               end else if (pos == 18) begin
                  stamp_st = SP_SECONDS;
               end
            SP_SECONDS, SP_FRAC:
               if (stamp_st == SP_FRAC && d) stamp_st = SP_FRAC;
               else if (stamp_st == SP_SECONDS && c == ".") stamp_st = SP_POINT;
               else if (c == "Z") begin
                  stamp_st  = SP_ZONE;
                  zone_seen = 1'b1;
               end else if (c == "+" || c == "-") stamp_st = SP_OFS_H1;
               else stamp_st = ST_DEAD;
            SP_POINT: stamp_st = d ? SP_FRAC : ST_DEAD;
            SP_OFS_H1, SP_OFS_H2, SP_OFS_M1:
               stamp_st = d ? stamp_st + 4'd1 : ST_DEAD;
            SP_OFS_COLON: stamp_st = (c == ":") ? SP_OFS_M1 : ST_DEAD;
            SP_OFS_M2:
               if (d) begin
                  stamp_st  = SP_ZONE;
                  zone_seen = 1'b1;
               end else stamp_st = ST_DEAD;
            default: stamp_st = ST_DEAD;
         endcase
      endfunction

      // priority: high byte (none), boolean, number, date, datetime
      function logic [2:0] verdict();
         if (high_byte) return KIND_NONE;
         if (bool_st == BL_TRUE || bool_st == BL_FALSE || bool_st == BL_TRAIL)
            return KIND_BOOL;
         if (num_st == NM_INT || num_st == NM_FRAC || num_st == NM_EXP_DIG ||
             num_st == NM_TRAIL)
            return num_frac_exp ? KIND_DEC : KIND_INT;
         if (stamp_st == SP_PREFIX && pos == 10 && date_valid()) return KIND_DATE;
         if (hms_ok && (stamp_st == SP_SECONDS || stamp_st == SP_FRAC)) return KIND_NAIVE;
         if (hms_ok && stamp_st == SP_ZONE && zone_seen) return KIND_ZONED;
         return KIND_NONE;
      endfunction

      function void note_input(logic [7:0] c, logic last, logic nochar);
         if (!nochar) begin
            if (c[7]) high_byte = 1'b1;
            step_bool(c);
            step_num(c);
            step_stamp(c);
            if (pos != POS_MAX) pos = pos + 5'd1;
            bytes_noted++;
         end
         if (last) begin
            kind_q.push_back(verdict());
            clear_cell();
         end
      endfunction

      function void check_result(logic [2:0] got);
         logic [2:0] want;
         if (got <= KIND_ZONED) kind_count[got]++;
         if (kind_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("ERROR: rsp_kind %0d with no cell pending", got);
            return;
         end
         want = kind_q.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= 10) $display("ERROR: kind expected %0d got %0d", want, got);
         end
      endfunction

      function int unsigned pending();
         return kind_q.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and DUT
   // -------------------------------------------------------------------------
   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_char_code = 8'h00;
   logic       req_last_char = 1'b0;
   logic       req_no_char = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [2:0] rsp_kind;

   always #1 clock = ~clock;

   cell_scalar_kind_classifier u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_char_code (req_char_code),
      .req_last_char (req_last_char),
      .req_no_char   (req_no_char),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_kind      (rsp_kind)
   );

   kind_scoreboard sb;

   int unsigned tx_pct = 0;        // chance per cycle that the sender idles
   int unsigned rx_pct = 0;        // chance per cycle that the receiver stalls
   bit          hold_request = 1'b0;
   int unsigned hold_left = 0;
   int unsigned hold_cycles = 150;
   int unsigned cells_sent = 0;
   int unsigned req_stalled = 0;   // cycles with an offer held back by the block
   logic [7:0]  cell_text[$];      // text of the cell being built

   // -------------------------------------------------------------------------
   // Receiver: stall decided at each falling edge. A hold request turns into
   // a long solid stall that is counted down here, cycle by cycle.
   // -------------------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left    = hold_cycles;
         hold_request = 1'b0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rx_pct);
      end
   end

   // Result monitor: every rsp_ transfer is checked at the rising edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_kind);
      if (!reset && req_valid && req_stall) req_stalled++;
   end

   // -------------------------------------------------------------------------
   // Sender. Payload changes only at a falling edge after a transfer, so a
   // stalled offer stays put. Valid drops only when an idle gap is chosen.
   // -------------------------------------------------------------------------
   task automatic send_item(logic [7:0] c, logic last, logic nochar);
      int unsigned gap;
      gap = 0;
      while (gap < 60 && $urandom_range(99) < tx_pct) gap++;
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_char_code <= c;
      req_last_char <= last;
      req_no_char   <= nochar;
      do @(posedge clock); while (!(req_valid && !req_stall));
      sb.note_input(c, last, nochar);
   endtask

   // Send cell_text as one cell. Empty-byte transfers are sprinkled in, and
   // some cells close with an empty-byte transfer instead of the last byte.
   task automatic send_cell();
      bit close_empty;
      close_empty = (cell_text.size() == 0) || ($urandom_range(99) < 12);
      foreach (cell_text[i]) begin
         if ($urandom_range(99) < 4) send_item(8'($urandom_range(255)), 1'b0, 1'b1);
         send_item(cell_text[i], !close_empty && (i == cell_text.size() - 1), 1'b0);
      end
      if (close_empty) send_item(8'($urandom_range(255)), 1'b1, 1'b1);
      cells_sent++;
   endtask

   // Directed cell from a literal string
   task automatic send_text(string s, bit close_empty);
      for (int k = 0; k < s.len(); k++)
         send_item(s[k], !close_empty && (k == s.len() - 1), 1'b0);
      if (close_empty) send_item(8'hAA, 1'b1, 1'b1);
      cells_sent++;
   endtask

   // -------------------------------------------------------------------------
   // Cell text builders
   // -------------------------------------------------------------------------
   function automatic logic [7:0] ws_char();
      int unsigned r;
      r = $urandom_range(5);
      return (r == 5) ? 8'h20 : 8'h09 + r[7:0];
   endfunction

   function automatic logic [7:0] rand_digit();
      return 8'h30 + 8'($urandom_range(9));
   endfunction

   function automatic logic [7:0] text_char();
      string pool;
      pool = " 0123456789+-.:eEtTZfalsru";
      return pool[$urandom_range(pool.len() - 1)];
   endfunction

   function automatic void put_text(string s);
      for (int k = 0; k < s.len(); k++) cell_text.push_back(s[k]);
   endfunction

   function automatic void put_digits(int unsigned value, int unsigned width);
      int unsigned div;
      div = 1;
      repeat (width - 1) div = div * 10;
      repeat (width) begin
         cell_text.push_back(8'h30 + 8'((value / div) % 10));
         div = div / 10;
      end
   endfunction

   // minute or second field, mostly in range
   function automatic int unsigned clock_field();
      return ($urandom_range(4) == 0) ? $urandom_range(99) : $urandom_range(59);
   endfunction

   // YYYY-MM-DD, biased toward leap-year and month-end corners
   function automatic void gen_date();
      int unsigned y, m, d, dim;
      case ($urandom_range(3))
         0:       y = $urandom_range(9999);
         1:       y = 4 * $urandom_range(2499);
         2:       y = 100 * $urandom_range(99);
         default: y = 400 * $urandom_range(24);
      endcase
      m   = ($urandom_range(9) < 8) ? $urandom_range(1, 12) : $urandom_range(99);
      dim = sb.days_in(y, m);
      case ($urandom_range(5))
         0:       d = 1;
         1:       d = dim;
         2:       d = dim + 1;
         3:       d = 29;
         4:       d = $urandom_range(1, 28);
         default: d = $urandom_range(99);
      endcase
      put_digits(y, 4);
      put_text("-");
      put_digits(m, 2);
      put_text("-");
      put_digits(d, 2);
   endfunction

   // -------------------------------------------------------------------------
   // One idle pattern: mostly well-formed cells with random content, some
   // of them broken, plus noise, long cells, blank and empty cells.
   // -------------------------------------------------------------------------
   task automatic run_phase(int unsigned tx, int unsigned rx, int unsigned nbytes);
      int unsigned start_bytes, start_cells, r, at;
      string word;
      logic [7:0] ch;
      tx_pct      = tx;
      rx_pct      = rx;
      start_bytes = sb.bytes_noted;
      start_cells = cells_sent;
      while (sb.bytes_noted - start_bytes < nbytes || cells_sent - start_cells < 12) begin
         cell_text.delete();
         r = $urandom_range(99);
         if (r < 12) begin
            // boolean word, random letter case, optional surrounding blanks
            if ($urandom_range(1)) word = "true";
            else word = "false";
            repeat ($urandom_range(2)) cell_text.push_back(ws_char());
            for (int k = 0; k < word.len(); k++) begin
               ch = word[k];
               if ($urandom_range(1)) ch = ch - 8'h20;
               cell_text.push_back(ch);
            end
            repeat ($urandom_range(2)) cell_text.push_back(ws_char());
         end else if (r < 34) begin
            // number: sign, mantissa with or without point, exponent
            repeat ($urandom_range(1)) cell_text.push_back(ws_char());
            case ($urandom_range(2))
               1:       put_text("+");
               2:       put_text("-");
               default: ;
            endcase
            if ($urandom_range(3) == 0) begin
               put_text(".");
               repeat ($urandom_range(1, 3)) cell_text.push_back(rand_digit());
            end else begin
               repeat ($urandom_range(1, 4)) cell_text.push_back(rand_digit());
               if ($urandom_range(2) == 0) begin
                  put_text(".");
                  repeat ($urandom_range(0, 3)) cell_text.push_back(rand_digit());
               end
            end
            if ($urandom_range(3) == 0) begin
               cell_text.push_back($urandom_range(1) ? "e" : "E");
               case ($urandom_range(2))
                  1:       put_text("+");
                  2:       put_text("-");
                  default: ;
               endcase
               repeat ($urandom_range(1, 2)) cell_text.push_back(rand_digit());
            end
            repeat ($urandom_range(1)) cell_text.push_back(ws_char());
         end else if (r < 54) begin
            gen_date();
         end else if (r < 80) begin
            // datetime with optional fraction and zone
            gen_date();
            put_text("T");
            put_digits(($urandom_range(3) == 0) ? $urandom_range(99) : $urandom_range(23), 2);
            put_text(":");
            put_digits(clock_field(), 2);
            put_text(":");
            put_digits(clock_field(), 2);
            if ($urandom_range(1)) begin
               put_text(".");
               repeat ($urandom_range(0, 4)) cell_text.push_back(rand_digit());
            end
            case ($urandom_range(2))
               1: put_text("Z");
               2: begin
                  cell_text.push_back($urandom_range(1) ? "+" : "-");
                  put_digits($urandom_range(99), 2);
                  put_text(":");
                  put_digits($urandom_range(99), 2);
               end
               default: ;
            endcase
         end else if (r < 90) begin
            // noise: any byte value, or bytes the grammars care about
            repeat ($urandom_range(1, 6))
               cell_text.push_back($urandom_range(1) ? 8'($urandom_range(255)) : text_char());
         end else if (r < 94) begin
            // longer than the position counter can count
            case ($urandom_range(2))
               0: repeat ($urandom_range(32, 40)) cell_text.push_back(rand_digit());
               1: begin
                  repeat (12) cell_text.push_back(ws_char());
                  repeat ($urandom_range(20, 28)) cell_text.push_back(rand_digit());
               end
               default: begin
                  gen_date();
                  put_text("T12:34:56.");
                  repeat ($urandom_range(14, 20)) cell_text.push_back(rand_digit());
                  put_text("Z");
               end
            endcase
         end else if (r < 97) begin
            repeat ($urandom_range(1, 3)) cell_text.push_back(ws_char());
         end
         // else: empty cell

         // break some well-formed cells: overwrite, truncate or extend
         if (r < 80 && cell_text.size() != 0 && $urandom_range(99) < 15) begin
            at = $urandom_range(cell_text.size() - 1);
            case ($urandom_range(2))
               0:       cell_text[at] = $urandom_range(1) ? 8'($urandom_range(255)) : text_char();
               1:       while (cell_text.size() > at) void'(cell_text.pop_back());
               default: cell_text.push_back(text_char());
            endcase
         end
         send_cell();
      end
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      int unsigned waited;
      sb = new();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed corners, no idling
      send_item(8'h00, 1'b1, 1'b1);        // empty cell
      send_item(8'h20, 1'b0, 1'b0);        // blanks only
      send_item(8'h09, 1'b1, 1'b0);
      send_item(8'h00, 1'b1, 1'b0);        // NUL byte is just a byte
      send_item(8'hFF, 1'b1, 1'b0);        // high byte forces none
      send_text("7", 1'b0);                // integer
      send_item("-", 1'b0, 1'b0);          // decimal with a no-byte transfer inside
      send_item(8'hFF, 1'b0, 1'b1);
      send_item(".", 1'b0, 1'b0);
      send_item("5", 1'b1, 1'b0);
      send_text("tRuE", 1'b1);             // boolean closed by a no-byte transfer
      send_text("2000-02-29", 1'b0);       // leap day of a 400-year
      cells_sent = cells_sent + 5;

      // four idle patterns, the first with no idling and one long receiver hold while bytes keep coming
      hold_request = 1'b1;
      run_phase(0, 0, 160);
      run_phase(88, 0, 145);
      run_phase(0, 88, 145);
      run_phase(33, 33, 145);

      @(negedge clock);
      req_valid <= 1'b0;

      waited = 0;
      while (sb.pending() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (10) @(posedge clock);

      $display("Covered %0d cells, %0d bytes, 4 idle patterns, %0d-cycle hold, %0d stalls",
               cells_sent, sb.bytes_noted, hold_cycles, req_stalled);
      $display("Kinds seen: none %0d bool %0d int %0d dec %0d date %0d naive %0d zoned %0d",
               sb.kind_count[0], sb.kind_count[1], sb.kind_count[2], sb.kind_count[3],
               sb.kind_count[4], sb.kind_count[5], sb.kind_count[6]);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("ERROR: %0d failures, %0d cells without a result", sb.errors, sb.pending());
         $display("== FAIL ==");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest legal run
   initial begin
      #2000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

[files.f]
design/cskc_pkg.sv
design/cskc_scan.sv
design/cell_scalar_kind_classifier.sv
tb/tb_cell_scalar_kind_classifier.sv
